>>> hw/rtl/glcp_pkg.sv
// ----------------------------------------------------------------------------
// glcp_pkg: shared constants and types of the LZW code packer
// Code and dictionary sizes, special codes and the code job passed from the
// dictionary control to the bit packer.
// ----------------------------------------------------------------------------
package glcp_pkg;

  localparam int unsigned DICT_CODES  = 4096;
  localparam int unsigned ALPHABET    = 256;
  localparam int unsigned ALPHA_W     = $clog2(ALPHABET);
  localparam int unsigned CODE_W      = $clog2(DICT_CODES);
  localparam int unsigned NFC_W       = CODE_W + 1;
  localparam int unsigned DICT_DEPTH  = DICT_CODES * ALPHABET;
  localparam int unsigned DICT_ADDR_W = $clog2(DICT_DEPTH);
  localparam int unsigned WID_W       = 4;
  localparam int unsigned START_WIDTH = 9;
  localparam int unsigned MAX_WIDTH   = 12;
  localparam int unsigned CLEAR_CODE  = ALPHABET;
  localparam int unsigned FIRST_FREE  = ALPHABET + 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ACC_W       = BYTE_W + MAX_WIDTH;
  localparam int unsigned USED_W      = $clog2(ACC_W + 1);
  localparam int unsigned JOB_SLOTS   = 3;
  localparam int unsigned SLOT_W      = 2;

  // up to three codes produced by one pixel, in stream order
  typedef struct packed {
    logic [SLOT_W-1:0]                cnt;
    logic [JOB_SLOTS-1:0][CODE_W-1:0] code;
    logic [JOB_SLOTS-1:0][WID_W-1:0]  wid;
    logic                             last;
  } glcp_job_t;

endpackage

>>> hw/rtl/glcp_if.sv
// ----------------------------------------------------------------------------
// glcp_if: pixel and byte stream channels
// Valid/ready channels carrying pixel indices in and packed code bytes out.
// ----------------------------------------------------------------------------
interface glcp_in_if;
  logic                        valid;
  logic                        ready;
  logic [glcp_pkg::ALPHA_W-1:0] pixel;
  logic                        last;

  modport source (output valid, output pixel, output last, input ready);
  modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface glcp_out_if;
  logic                       valid;
  logic                       ready;
  logic [glcp_pkg::BYTE_W-1:0] data_byte;
  logic                       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

>>> hw/rtl/glcp_ram.sv
// ----------------------------------------------------------------------------
// glcp_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle, read data registered on read enable.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module glcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  // two-state storage: never-written entries read as a defined value
  bit   [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/glcp_packer.sv
// ----------------------------------------------------------------------------
// glcp_packer: LSB-first bit packer for variable width codes
// Merges one code per cycle into a bit accumulator while it holds under a byte and no flush pends, and
// sends one byte per cycle while out is ready; after an image's last code the partial byte is flushed.
// ----------------------------------------------------------------------------
module glcp_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  glcp_pkg::glcp_job_t job_i,
  output logic                job_busy_o,
  glcp_out_if.source          out_o
);

  glcp_pkg::glcp_job_t                 job_q;
  logic                                job_busy_q;
  logic [glcp_pkg::SLOT_W-1:0]         slot_q;
  logic [glcp_pkg::ACC_W-1:0]          acc_q, acc_d, acc_s;
  logic [glcp_pkg::USED_W-1:0]         used_q, used_d, used_s;
  logic                                flush_q, flush_d, flush_s;
  logic                                out_valid_q;
  logic [glcp_pkg::BYTE_W-1:0]         out_byte_q;
  logic                                out_final_q;

  logic                                out_free, has_byte, emit, fin;
  logic                                merge, job_end;
  logic [glcp_pkg::CODE_W-1:0]         cur_code;
  logic [glcp_pkg::WID_W-1:0]          cur_wid;
  logic [glcp_pkg::ACC_W-1:0]          code_ext;

  always_comb begin
    out_free = !out_valid_q || out_o.ready;
    has_byte = (used_q >= glcp_pkg::USED_W'(glcp_pkg::BYTE_W)) ||
               (flush_q && (used_q != '0));
    emit     = out_free && has_byte;
    // last byte of the image: flushing and nothing left beyond this byte
    fin      = flush_q && (used_q <= glcp_pkg::USED_W'(glcp_pkg::BYTE_W));

    if (emit && fin) begin
      acc_s  = '0;
      used_s = '0;
    end else if (emit) begin
      acc_s  = acc_q >> glcp_pkg::BYTE_W;
      used_s = used_q - glcp_pkg::USED_W'(glcp_pkg::BYTE_W);
    end else begin
      acc_s  = acc_q;
      used_s = used_q;
    end
    flush_s = flush_q && !(emit && fin) && (used_q != '0);

    cur_code = job_q.code[slot_q];
    cur_wid  = job_q.wid[slot_q];
    code_ext = glcp_pkg::ACC_W'(cur_code) &
               ((glcp_pkg::ACC_W'(1) << cur_wid) - glcp_pkg::ACC_W'(1));

    merge   = job_busy_q && !flush_s && (used_s < glcp_pkg::USED_W'(glcp_pkg::BYTE_W));
    job_end = merge && (slot_q == (job_q.cnt - glcp_pkg::SLOT_W'(1)));

    acc_d   = merge ? (acc_s | (code_ext << used_s)) : acc_s;
    used_d  = merge ? (used_s + glcp_pkg::USED_W'(cur_wid)) : used_s;
    flush_d = flush_s || (job_end && job_q.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_busy_q  <= 1'b0;
      slot_q      <= '0;
      acc_q       <= '0;
      used_q      <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      used_q  <= used_d;
      flush_q <= flush_d;
      if (job_valid_i) begin
        job_busy_q <= 1'b1;
        slot_q     <= '0;
      end else if (merge) begin
        if (job_end) begin
          job_busy_q <= 1'b0;
        end else begin
          slot_q <= slot_q + glcp_pkg::SLOT_W'(1);
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_byte_q  <= acc_q[glcp_pkg::BYTE_W-1:0];
      out_final_q <= fin;
    end
  end

  assign job_busy_o       = job_busy_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.data_byte  = out_byte_q;
  assign out_o.final_byte = out_final_q;

endmodule

>>> hw/rtl/gif_lzw_code_packer.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_packer: GIF-style LZW encoder with 12-bit codes, byte output
// Looks up (prefix, pixel) in a dictionary RAM, checks the hit against a
// code-to-address RAM and hands the resulting codes to an LSB-first packer.
//
//   channel | dir | beat payload          | note
//   in_i    | in  | pixel[7:0], last      | one palette index per beat
//   out_o   | out | data_byte[7:0],       | final_byte marks the last byte
//           |     | final_byte            | of an image's stream
//
// A pixel passes through the dictionary read, then the code-to-address read,
// then the hit decision, which also issues the next pixel's dictionary read.
// A hit is a stored code in [258, next free code) whose code-to-address entry
// points back at the looked-up address, so the RAMs need no clearing pass:
// reset and table restarts take effect at once.
// A stalled output holds pixels back once the packer's job slot is full.
// ----------------------------------------------------------------------------
module gif_lzw_code_packer (
  input  logic      clk_i,
  input  logic      rst_ni,
  glcp_in_if.sink   in_i,
  glcp_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE
  } lzw_state_e;

  lzw_state_e                        state_q;
  logic [glcp_pkg::CODE_W-1:0]       prefix_q, prefix_d;
  logic [glcp_pkg::NFC_W-1:0]        nfc_q, nfc_d;
  logic [glcp_pkg::WID_W-1:0]        width_q, width_d;
  logic                              first_q, first_d;
  logic                              fwd_q;
  logic [glcp_pkg::NFC_W-1:0]        fwd_data_q;
  logic [glcp_pkg::ALPHA_W-1:0]      pix_q;
  logic                              last_q;
  logic [glcp_pkg::DICT_ADDR_W-1:0]  idx_q;

  logic [glcp_pkg::NFC_W-1:0]        dict_rdata, dict_v;
  logic [glcp_pkg::DICT_ADDR_W-1:0]  c2a_rdata;
  logic [glcp_pkg::DICT_ADDR_W-1:0]  dict_raddr;
  logic                              dict_we, hit, table_full;
  logic                              dec_go, accept, job_busy;
  logic [glcp_pkg::CODE_W-1:0]       prefix_rd;
  glcp_pkg::glcp_job_t               job;

  assign dict_v     = fwd_q ? fwd_data_q : dict_rdata;
  assign table_full = nfc_q >= glcp_pkg::NFC_W'(glcp_pkg::DICT_CODES);
  assign hit        = (dict_v >= glcp_pkg::NFC_W'(glcp_pkg::FIRST_FREE)) &&
                      (dict_v < nfc_q) && (c2a_rdata == idx_q);

  always_comb begin
    job      = '0;
    job.last = last_q;
    prefix_d = prefix_q;
    nfc_d    = nfc_q;
    width_d  = width_q;
    first_d  = first_q;

    if (first_q) begin
      job.code[job.cnt] = glcp_pkg::CODE_W'(glcp_pkg::CLEAR_CODE);
      job.wid[job.cnt]  = width_q;
      job.cnt           = job.cnt + glcp_pkg::SLOT_W'(1);
      prefix_d          = glcp_pkg::CODE_W'(pix_q);
      first_d           = 1'b0;
    end else if (hit) begin
      prefix_d = dict_v[glcp_pkg::CODE_W-1:0];
    end else begin
      job.code[job.cnt] = prefix_q;
      job.wid[job.cnt]  = width_q;
      job.cnt           = job.cnt + glcp_pkg::SLOT_W'(1);
      if (!table_full) begin
        nfc_d = nfc_q + glcp_pkg::NFC_W'(1);
        // grow once the code just assigned no longer fits the width
        if ((nfc_q >= (glcp_pkg::NFC_W'(1) << width_q)) &&
            (nfc_d < glcp_pkg::NFC_W'(glcp_pkg::DICT_CODES)) &&
            (width_q < glcp_pkg::WID_W'(glcp_pkg::MAX_WIDTH))) begin
          width_d = width_q + glcp_pkg::WID_W'(1);
        end
      end else begin
        job.code[job.cnt] = glcp_pkg::CODE_W'(glcp_pkg::CLEAR_CODE);
        job.wid[job.cnt]  = width_q;
        job.cnt           = job.cnt + glcp_pkg::SLOT_W'(1);
        nfc_d             = glcp_pkg::NFC_W'(glcp_pkg::FIRST_FREE);
        width_d           = glcp_pkg::WID_W'(glcp_pkg::START_WIDTH);
      end
      prefix_d = glcp_pkg::CODE_W'(pix_q);
    end

    if (last_q) begin
      job.code[job.cnt] = prefix_d;
      job.wid[job.cnt]  = width_d;
      job.cnt           = job.cnt + glcp_pkg::SLOT_W'(1);
      prefix_d          = '0;
      nfc_d             = glcp_pkg::NFC_W'(glcp_pkg::FIRST_FREE);
      width_d           = glcp_pkg::WID_W'(glcp_pkg::START_WIDTH);
      first_d           = 1'b1;
    end
  end

  assign dec_go     = (state_q == ST_DECIDE) && ((job.cnt == '0) || !job_busy);
  assign in_i.ready = (state_q == ST_IDLE) || dec_go;
  assign accept     = in_i.valid && in_i.ready;
  assign prefix_rd  = dec_go ? prefix_d : prefix_q;
  assign dict_raddr = {prefix_rd, in_i.pixel};
  assign dict_we    = dec_go && !first_q && !hit && !table_full;

  glcp_ram #(
    .WIDTH (glcp_pkg::NFC_W),
    .DEPTH (glcp_pkg::DICT_DEPTH)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (idx_q),
    .wdata_i (nfc_q),
    .re_i    (accept),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  glcp_ram #(
    .WIDTH (glcp_pkg::DICT_ADDR_W),
    .DEPTH (glcp_pkg::DICT_CODES)
  ) u_c2a_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (nfc_q[glcp_pkg::CODE_W-1:0]),
    .wdata_i (idx_q),
    .re_i    (state_q == ST_LOOK),
    .raddr_i (dict_v[glcp_pkg::CODE_W-1:0]),
    .rdata_o (c2a_rdata)
  );

  glcp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (dec_go && (job.cnt != '0)),
    .job_i       (job),
    .job_busy_o  (job_busy),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prefix_q <= '0;
      nfc_q    <= glcp_pkg::NFC_W'(glcp_pkg::FIRST_FREE);
      width_q  <= glcp_pkg::WID_W'(glcp_pkg::START_WIDTH);
      first_q  <= 1'b1;
      fwd_q    <= 1'b0;
    end else begin
      if (dec_go) begin
        prefix_q <= prefix_d;
        nfc_q    <= nfc_d;
        width_q  <= width_d;
        first_q  <= first_d;
      end
      if (accept) begin
        // same-entry write in this cycle: the RAM returns old data
        fwd_q <= dict_we && (idx_q == dict_raddr);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (accept) begin
            state_q <= ST_LOOK;
          end else if (dec_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q      <= in_i.pixel;
      last_q     <= in_i.last;
      idx_q      <= dict_raddr;
      fwd_data_q <= nfc_q;
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gif_lzw_code_packer
// Pixel images go in on a bursty valid/ready channel and the packed bytes are
// taken on a stalling receiver. Each byte is checked against hand-written
// bytes or a behavioral LZW packer kept alongside. A short table of hand-picked
// images comes first, then random images of varied length and symbol spread.
// One longer image drives the code width past 9 bits.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned N_DIR      = 22;
  localparam int unsigned RAND_ITEMS = 50;
  localparam int unsigned GROW_ITEMS = 280;

  typedef struct packed {
    logic [7:0]      data;
    logic            fin;
  } byte_beat_t;

  // pixel, last, count of hand-written bytes, bytes {b2, b1, b0}
  typedef struct packed {
    logic [7:0]      pixel;
    logic            last;
    logic [1:0]      n_fix;
    logic [2:0][7:0] fix;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  glcp_in_if  in_if ();
  glcp_out_if out_if ();

  gif_lzw_code_packer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // single-pixel images: clear code then the pixel at 9 bits, 18 bits in all
  stim_row_t dir_tab [N_DIR] = '{
    '{8'hFF, 1'b1, 2'd3, {8'h01, 8'hFF, 8'h00}},
    '{8'h00, 1'b1, 2'd3, {8'h00, 8'h01, 8'h00}},
    '{8'h80, 1'b1, 2'd3, {8'h01, 8'h01, 8'h00}},
    '{8'h01, 1'b1, 2'd3, {8'h00, 8'h03, 8'h00}},
    // run of one symbol, mostly dictionary hits
    '{8'h01, 1'b0, 2'd0, 24'h0},
    '{8'h01, 1'b0, 2'd0, 24'h0},
    '{8'h01, 1'b0, 2'd0, 24'h0},
    '{8'h01, 1'b0, 2'd0, 24'h0},
    '{8'h01, 1'b0, 2'd0, 24'h0},
    '{8'h01, 1'b1, 2'd0, 24'h0},
    // eight 9-bit codes end exactly on a byte boundary
    '{8'h0A, 1'b0, 2'd0, 24'h0},
    '{8'h14, 1'b0, 2'd0, 24'h0},
    '{8'h1E, 1'b0, 2'd0, 24'h0},
    '{8'h28, 1'b0, 2'd0, 24'h0},
    '{8'h32, 1'b0, 2'd0, 24'h0},
    '{8'h3C, 1'b0, 2'd0, 24'h0},
    '{8'h46, 1'b1, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b1, 2'd0, 24'h0}
  };

  // expected byte stream and behavioral encoder state
  byte_beat_t                     byte_q[$];
  byte_beat_t                     step_beats[$];
  logic [glcp_pkg::NFC_W-1:0]     code_map [int unsigned];
  logic [glcp_pkg::CODE_W-1:0]    pfx;
  logic [glcp_pkg::NFC_W-1:0]     next_code;
  logic [glcp_pkg::WID_W-1:0]     cwid;
  logic [7:0]                     pend_bits;
  int unsigned                    pend_cnt;
  bit                             new_image;

  int unsigned           err_cnt;
  int unsigned           burst_left;
  logic [1:0]            rx_mode;
  int unsigned           rx_phase;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("gif_lzw_code_packer regression: fail");
    $finish;
  end

  function automatic void lzw_restart();
    code_map.delete();
    next_code = glcp_pkg::NFC_W'(glcp_pkg::FIRST_FREE);
    cwid      = glcp_pkg::WID_W'(glcp_pkg::START_WIDTH);
  endfunction

  function automatic void lzw_init();
    lzw_restart();
    pfx       = '0;
    pend_bits = '0;
    pend_cnt  = 0;
    new_image = 1'b1;
  endfunction

  // append a code LSB-first, emitting every byte that fills up
  function automatic void pack_code(input int unsigned code, input int unsigned w);
    logic [31:0] acc;
    acc = {24'b0, pend_bits} | ((code & ((32'd1 << w) - 1)) << pend_cnt);
    pend_cnt += w;
    while (pend_cnt >= 8) begin
      step_beats.push_back('{data: acc[7:0], fin: 1'b0});
      acc = acc >> 8;
      pend_cnt -= 8;
    end
    pend_bits = acc[7:0];
  endfunction

  function automatic void lzw_encode(input logic [7:0] pix, input logic lst);
    int unsigned key;
    byte_beat_t  tail;
    step_beats.delete();
    if (new_image) begin
      pack_code(glcp_pkg::CLEAR_CODE, cwid);
      pfx       = glcp_pkg::CODE_W'(pix);
      new_image = 1'b0;
    end else begin
      key = pfx * glcp_pkg::ALPHABET + pix;
      if (code_map.exists(key)) begin
        pfx = glcp_pkg::CODE_W'(code_map[key]);
      end else begin
        pack_code(pfx, cwid);
        if (next_code < glcp_pkg::DICT_CODES) begin
          code_map[key] = next_code;
          next_code     = next_code + 1'b1;
        end else begin
          // table full: send clear at the current width and start over
          pack_code(glcp_pkg::CLEAR_CODE, cwid);
          lzw_restart();
        end
        if (((32'd1 << cwid) - 1) < (32'(next_code) - 1) &&
            next_code < glcp_pkg::DICT_CODES && cwid < glcp_pkg::MAX_WIDTH) begin
          cwid = cwid + 1'b1;
        end
        pfx = glcp_pkg::CODE_W'(pix);
      end
    end
    if (lst) begin
      pack_code(pfx, cwid);
      if (pend_cnt != 0) begin
        step_beats.push_back('{data: pend_bits, fin: 1'b0});
      end
      lzw_init();
      if (step_beats.size() != 0) begin
        tail     = step_beats.pop_back();
        tail.fin = 1'b1;
        step_beats.push_back(tail);
      end
    end
  endfunction

  task automatic send_pixel(input logic [7:0] pix, input logic lst,
                            input logic [1:0] n_fix, input logic [2:0][7:0] fix);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    in_if.valid <= 1'b1;
    in_if.pixel <= pix;
    in_if.last  <= lst;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    burst_left--;
    lzw_encode(pix, lst);
    if (n_fix != 0) begin
      for (int k = 0; k < n_fix; k++) begin
        byte_q.push_back('{data: fix[k], fin: (lst && (k == n_fix - 1))});
      end
    end else begin
      foreach (step_beats[k]) byte_q.push_back(step_beats[k]);
    end
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (byte_q.size() != 0);
  endtask

  task automatic send_image(input int unsigned len, input int unsigned span);
    logic [7:0] base;
    logic [7:0] pix;
    base = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      pix = 8'(base + $urandom_range(0, span - 1));
      send_pixel(pix, (i == len - 1), 2'd0, '0);
    end
  endtask

  // receiver stall pattern, switching to a random mode whenever rx_phase runs down to zero
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode      <= 2'd0;
      rx_phase     <= 0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  <= 2'($urandom_range(0, 3));
        rx_phase <= $urandom_range(16, 128);
      end else begin
        rx_phase <= rx_phase - 1;
      end
      case (rx_mode)
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (rx_phase % 16 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (byte_q.size() == 0) begin
        $error("unexpected beat: data_byte %02h final_byte %0b",
               out_if.data_byte, out_if.final_byte);
        err_cnt++;
      end else begin
        byte_beat_t want;
        want = byte_q.pop_front();
        if (out_if.data_byte !== want.data) begin
          $error("data_byte: expected %02h, actual %02h", want.data, out_if.data_byte);
          err_cnt++;
        end
        if (out_if.final_byte !== want.fin) begin
          $error("final_byte: expected %0b, actual %0b", want.fin, out_if.final_byte);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned span;
    int unsigned guard;
    err_cnt     = 0;
    burst_left  = 0;
    in_if.valid <= 1'b0;
    in_if.pixel <= '0;
    in_if.last  <= 1'b0;
    rst_ni      <= 1'b0;
    lzw_init();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      send_pixel(dir_tab[r].pixel, dir_tab[r].last, dir_tab[r].n_fix, dir_tab[r].fix);
    end
    hold_until_drained();

    // short images; narrow symbol spreads give long dictionary matches
    sent = 0;
    while (sent < RAND_ITEMS) begin
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
      case ($urandom_range(0, 3))
        0: span = 2;
        1: span = 4;
        2: span = 16;
        default: span = 256;
      endcase
      send_image(len, span);
      sent += len;
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    // mostly misses, enough new codes to step the width up to 10
    send_image(GROW_ITEMS, 256);
    in_if.valid <= 1'b0;

    guard = 0;
    while (byte_q.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (byte_q.size() != 0) begin
      $error("%0d expected bytes never arrived", byte_q.size());
      err_cnt += byte_q.size();
    end
    if (err_cnt == 0) begin
      $display("gif_lzw_code_packer regression: pass");
    end else begin
      $display("gif_lzw_code_packer regression: fail");
    end
    $finish;
  end

endmodule
